@@ sv/scharr_gradient_magnitude_core_assert.svh @@
// Assertion macros for the Scharr gradient magnitude core.
// Expects clk and rst_n in the scope of the including module.
`ifndef SCHARR_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH
`define SCHARR_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SGM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgm assertion failed");

`endif

@@ sv/sgm_pkg.sv @@
// Shared types, constants and helpers for the Scharr gradient magnitude core.
// No dependencies.
`timescale 1ns / 1ps
package sgm_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 12;
    localparam int ROW_W     = HEIGHT_W + 1;
    localparam int GRAD_W    = 13;
    localparam int SQ_W      = 25;
    localparam int ROOT_W    = 13;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_HOLD
    } sgm_state_t;

    // [col][row]: col 0 oldest, row 0 top
    typedef logic [2:0][2:0][7:0] sgm_win_t;

    // Pick three window columns; optionally replace the top row by the bottom.
    function automatic sgm_win_t sgm_pick(input sgm_win_t win, input logic [1:0] lc,
                                          input logic [1:0] cc, input logic [1:0] rc,
                                          input logic flip);
        sgm_win_t nb;
        nb[0] = win[lc];
        nb[1] = win[cc];
        nb[2] = win[rc];
        if (flip)
        begin
            nb[0][0] = nb[0][2];
            nb[1][0] = nb[1][2];
            nb[2][0] = nb[2][2];
        end
        return nb;
    endfunction

endpackage

@@ sv/sgm_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on sgm_pkg.
`timescale 1ns / 1ps
module sgm_isqrt
    import sgm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [SQ_W:0]   trial;
    logic            fits;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign fits  = {1'b0, v_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (busy_reg && bit_reg == SQ_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
                done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 1);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                v_reg   <= v_reg - trial[SQ_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

@@ sv/scharr_gradient_magnitude_core.sv @@
// Scharr 3x3 gradient magnitude core: top level with line memories and window.
// Depends on sgm_pkg, sgm_isqrt and scharr_gradient_magnitude_core_assert.svh.
//
// Usage:
//   Input stream: one word per pixel in raster order. tdata carries the gray
//   level, tuser selects a flush step. After the last pixel of a frame send
//   image_width+1 flush words to drain the last row; the final output word
//   of the frame carries tlast. A flush before the frame is complete is
//   dropped without a result.
//   Output stream: tdata carries the gradient magnitude (floored square
//   root of gx^2 + gy^2), outputs lag the input by image_width+1 words.
//   Throughput: one word at a time. A word with a result passes from
//   accept to output register through the read step (skipped for the final
//   drain word), the gradient step, the square-root start and the
//   bit-serial square root (13 steps and a done step); the next word is
//   accepted in the cycle after the result is loaded. A word without a
//   result takes only the read step; a dropped flush only the idle state.
//   The next word is accepted while a finished result waits in the output
//   register; when the receiver stalls, a second result holds the core until
//   the register frees.
//   Reset: counters and window clear, sizes return to 640 x 480. Line
//   memories are not cleared; the first row never reads them for output.
//   Configuration: write image_width / image_height only while idle.
`timescale 1ns / 1ps
`include "scharr_gradient_magnitude_core_assert.svh"
module scharr_gradient_magnitude_core
    import sgm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] pixel
    input  logic                s_axis_tuser,   // [0] operation
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [12:0] magnitude, rest zero
    output logic                m_axis_tlast,   // last_of_frame
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [HEIGHT_W-1:0] cfg_data
);

    sgm_state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  img_width_reg;
    logic [HEIGHT_W-1:0] img_height_reg;
    logic [COL_W-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]    row_cnt_reg, row_cnt_next;
    sgm_win_t            win_reg, win_next;
    sgm_win_t            nb_reg, nb_next;
    logic [7:0]          pix_reg;
    logic                last_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic                out_valid_reg;
    logic [ROOT_W-1:0]   out_mag_reg;
    logic                out_last_reg;

    // Line memories: line_a holds the previous row, line_b the row before it.
    logic [7:0] line_a [MAX_WIDTH];
    logic [7:0] line_b [MAX_WIDTH];
    logic [7:0] rd_a_reg, rd_b_reg;

    logic             accept;
    logic [ROW_W-1:0] height_ext;
    logic             drain;
    logic             early_flush;
    logic             at_bottom;
    logic [7:0]       new_pix;
    logic             case_a, case_b;
    logic             has_result;
    logic             out_free;
    logic             sq_start;
    logic             sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [SQ_W:0]    sq_sum;
    logic signed [2*GRAD_W-1:0] sqx, sqy;
    logic signed [GRAD_W:0] gx_wide, gy_wide;
    logic [WIDTH_W-1:0] col_plus;
    logic             load_out;
    logic             do_read;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign height_ext  = {1'b0, img_height_reg};
    assign drain       = row_cnt_reg > height_ext;
    assign early_flush = (row_cnt_reg < height_ext) && s_axis_tuser;
    assign at_bottom   = row_cnt_reg == height_ext;
    // On the bottom drain, feed the row two above as a virtual row.
    assign new_pix     = at_bottom ? rd_b_reg : pix_reg;
    assign case_a      = (col_cnt_reg == '0) && (row_cnt_reg >= ROW_W'(2));
    assign case_b      = (col_cnt_reg != '0) && (row_cnt_reg >= ROW_W'(1));
    assign has_result  = case_a || case_b;
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign col_plus    = {1'b0, col_cnt_reg} + WIDTH_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && drain)
                    state_next = ST_GRAD;
                else if (accept && !early_flush)
                    state_next = ST_READ;
            ST_READ:
                state_next = has_result ? ST_GRAD : ST_IDLE;
            ST_GRAD:
                state_next = ST_SQUARE;
            ST_SQUARE:
                state_next = ST_ROOT;
            ST_ROOT:
                if (sq_done)
                    state_next = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        do_read       = 1'b0;
        sq_start      = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_READ:   do_read       = 1'b1;
            ST_GRAD:   ;
            ST_SQUARE: sq_start      = 1'b1;
            ST_ROOT:   load_out      = sq_done && out_free;
            ST_HOLD:   load_out      = out_free;
            default:   ;
        endcase
    end

    // Window, neighborhood and counter updates
    always_comb
    begin
        win_next     = win_reg;
        nb_next      = nb_reg;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept && drain)
        begin
            // Final drain step: emit and restart the frame.
            nb_next      = sgm_pick(win_reg, 2'd1, 2'd2, 2'd1, 1'b0);
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (do_read)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = {new_pix, rd_a_reg, rd_b_reg};
            if (case_a)
                nb_next = sgm_pick(win_reg, 2'd1, 2'd2, 2'd1, row_cnt_reg == ROW_W'(2));
            else
                nb_next = sgm_pick(win_next, (col_cnt_reg == COL_W'(1)) ? 2'd2 : 2'd0,
                                   2'd1, 2'd2, row_cnt_reg == ROW_W'(1));
            if (col_plus >= img_width_reg)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_cnt_reg + ROW_W'(1);
            end
            else
                col_cnt_next = col_plus[COL_W-1:0];
        end
    end

    // Scharr sums, weights 3,10,3
    always_comb
    begin
        gx_wide = (GRAD_W+1)'(3)  * ($signed({6'b0, nb_reg[2][0]}) - $signed({6'b0, nb_reg[0][0]}))
                + (GRAD_W+1)'(10) * ($signed({6'b0, nb_reg[2][1]}) - $signed({6'b0, nb_reg[0][1]}))
                + (GRAD_W+1)'(3)  * ($signed({6'b0, nb_reg[2][2]}) - $signed({6'b0, nb_reg[0][2]}));
        gy_wide = (GRAD_W+1)'(3)  * ($signed({6'b0, nb_reg[0][2]}) - $signed({6'b0, nb_reg[0][0]}))
                + (GRAD_W+1)'(10) * ($signed({6'b0, nb_reg[1][2]}) - $signed({6'b0, nb_reg[1][0]}))
                + (GRAD_W+1)'(3)  * ($signed({6'b0, nb_reg[2][2]}) - $signed({6'b0, nb_reg[2][0]}));
    end

    assign sqx    = gx_reg * gx_reg;
    assign sqy    = gy_reg * gy_reg;
    assign sq_sum = sqx[SQ_W:0] + sqy[SQ_W:0];

    sgm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_sum[SQ_W-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            img_width_reg  <= WIDTH_W'(640);
            img_height_reg <= HEIGHT_W'(480);
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            win_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            win_reg     <= win_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:
                        if (cfg_data[WIDTH_W-1:0] < WIDTH_W'(3))
                            img_width_reg <= WIDTH_W'(3);
                        else if (cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH))
                            img_width_reg <= WIDTH_W'(MAX_WIDTH);
                        else
                            img_width_reg <= cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT:
                        if (cfg_data < HEIGHT_W'(3))
                            img_height_reg <= HEIGHT_W'(3);
                        else
                            img_height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= s_axis_tdata;
            last_reg <= drain;
        end
        nb_reg <= nb_next;
        if (state_reg == ST_GRAD)
        begin
            gx_reg <= gx_wide[GRAD_W-1:0];
            gy_reg <= gy_wide[GRAD_W-1:0];
        end
        if (load_out)
        begin
            out_mag_reg  <= sq_root;
            out_last_reg <= last_reg;
        end
    end

    // Line memories: read every cycle at the column, write back on the read step.
    always_ff @(posedge clk)
    begin
        rd_a_reg <= line_a[col_cnt_reg];
        rd_b_reg <= line_b[col_cnt_reg];
        if (do_read)
        begin
            line_a[col_cnt_reg] <= new_pix;
            line_b[col_cnt_reg] <= rd_a_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_mag_reg};
    assign m_axis_tlast  = out_last_reg;

    `SGM_ASSERT_SAME(a_root_done_in_root, sq_done, state_reg == ST_ROOT)
    `SGM_ASSERT_NEXT(a_drain_restarts, accept && drain,
                     state_reg == ST_GRAD && row_cnt_reg == '0 && col_cnt_reg == '0)
    `SGM_ASSERT_NEXT(a_hold_waits, state_reg == ST_HOLD && out_valid_reg && !m_axis_tready,
                     state_reg == ST_HOLD)

endmodule
